>>> rtl/clh_pkg.sv
// constants, types and the bucket search shared by the latency histogram
// no dependencies

package clh_pkg;

  localparam int NUM_CLASSES_DEF = 64;
  localparam int NUM_BUCKETS     = 12;
  localparam int SLOTS_PER_CLASS = NUM_BUCKETS + 2;
  localparam int CLASS_W         = 6;
  localparam int LAT_W           = 64;
  localparam int SLOT_W          = 4;
  localparam int WORD_W          = 64;
  localparam int IN_DATA_W       = 80;

  localparam logic [SLOT_W-1:0] SLOT_COUNT = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_TIME  = 4'd13;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t BUCKET_EDGES [NUM_BUCKETS-1] = '{
    64'd100, 64'd500, 64'd1000, 64'd5000, 64'd10000, 64'd50000,
    64'd100000, 64'd500000, 64'd1000000, 64'd5000000, 64'd10000000
  };

  function automatic logic [SLOT_W-1:0] bucket_of(input word_t lat);
    logic [SLOT_W-1:0] idx;
    idx = SLOT_W'(NUM_BUCKETS - 1);
    for (int i = NUM_BUCKETS - 2; i >= 0; i--) begin
      if (lat <= BUCKET_EDGES[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> rtl/clh_ram.sv
// counter store: one write port, one read port with registered read data
// depends on clh_pkg

module clh_ram
  import clh_pkg::*;
#(
  parameter int DEPTH  = NUM_CLASSES_DEF * SLOTS_PER_CLASS,
  parameter int ADDR_W = $clog2(NUM_CLASSES_DEF * SLOTS_PER_CLASS)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  word_t             wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output word_t             rd_data
);

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/command_latency_histogram.sv
// per-class latency statistics: count, twelve buckets and total time per class
// depends on clh_pkg and clh_ram

// After reset the block sweeps its counter memory to zero, one word a cycle,
// with s_tready low. Then it takes one transaction at a time: a record steps
// through read, time, count and bucket states, a drain through read and clear,
// and an out-of-range class or drain slot goes straight to the result. The
// steps are set by the single read and write port of the counter memory,
// through which a record reads and writes back total time, count and bucket
// word in turn. The next transaction can be accepted while a result waits in
// the output register.

module command_latency_histogram
  import clh_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,  // command_class[5:0], latency_us[69:6], slot[73:70]
  input  logic                 s_tuser,  // mode
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [WORD_W-1:0]    m_tdata,  // value[63:0]
  output logic                 m_tuser   // accepted
);

  localparam int DEPTH  = NUM_CLASSES * SLOTS_PER_CLASS;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_REC_RD   = 9'b000000100,
    S_REC_TIME = 9'b000001000,
    S_REC_CNT  = 9'b000010000,
    S_REC_BKT  = 9'b000100000,
    S_DRN_RD   = 9'b001000000,
    S_DRN_CLR  = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t state;

  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] base;
  word_t             lat;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] bkt;
  word_t             res_value;
  logic              res_accepted;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  word_t             wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  word_t             rd_data;

  logic [CLASS_W-1:0] in_class;
  logic [SLOT_W-1:0]  in_slot;
  logic               in_fire;
  logic               class_ok;
  logic               out_load;

  assign in_class = s_tdata[5:0];
  assign in_slot  = s_tdata[73:70];
  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign class_ok = 32'(in_class) < 32'(NUM_CLASSES);
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  clh_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = base + ADDR_W'(SLOT_TIME);
    unique case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_REC_RD: begin
        rd_en = 1'b1;
      end
      S_REC_TIME: begin
        wr_en   = 1'b1;
        wr_addr = base + ADDR_W'(SLOT_TIME);
        wr_data = rd_data + lat;
        rd_en   = 1'b1;
        rd_addr = base + ADDR_W'(SLOT_COUNT);
      end
      S_REC_CNT: begin
        wr_en   = 1'b1;
        wr_addr = base + ADDR_W'(SLOT_COUNT);
        wr_data = rd_data + WORD_W'(1);
        rd_en   = 1'b1;
        rd_addr = base + ADDR_W'(bkt) + ADDR_W'(1);
      end
      S_REC_BKT: begin
        wr_en   = 1'b1;
        wr_addr = base + ADDR_W'(bkt) + ADDR_W'(1);
        wr_data = rd_data + WORD_W'(1);
      end
      S_DRN_RD: begin
        rd_en   = 1'b1;
        rd_addr = base + ADDR_W'(slot);
      end
      S_DRN_CLR: begin
        wr_en   = 1'b1;
        wr_addr = base + ADDR_W'(slot);
      end
      S_IDLE, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            if (!class_ok) begin
              state <= S_DONE;
            end else if (!s_tuser) begin
              state <= S_REC_RD;
            end else if (in_slot <= SLOT_TIME) begin
              state <= S_DRN_RD;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_REC_RD:   state <= S_REC_TIME;
        S_REC_TIME: state <= S_REC_CNT;
        S_REC_CNT:  state <= S_REC_BKT;
        S_REC_BKT:  state <= S_DONE;
        S_DRN_RD:   state <= S_DRN_CLR;
        S_DRN_CLR:  state <= S_DONE;
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      base         <= ADDR_W'(32'(in_class) * 32'(SLOTS_PER_CLASS));
      lat          <= s_tdata[69:6];
      slot         <= in_slot;
      res_value    <= '0;
      res_accepted <= class_ok;
    end
    if (state == S_REC_RD) begin
      bkt <= bucket_of(lat);
    end
    if (state == S_REC_TIME) begin
      res_value <= rd_data + lat;
    end
    if (state == S_DRN_CLR) begin
      res_value <= rd_data;
    end
    if (out_load) begin
      m_tdata <= res_value;
      m_tuser <= res_accepted;
    end
  end

endmodule

>>> rtl/clh_checker.sv
// port-level checks for command_latency_histogram, bound to the top level
// depends on clh_pkg

module clh_checker
  import clh_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [IN_DATA_W-1:0] s_tdata,
  input logic                 s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [WORD_W-1:0]    m_tdata,
  input logic                 m_tuser
);

  // store sweep keeps input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("input open or result shown right after reset");

  // one transaction in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transaction accepted back to back");

  // rejected class carries a zero value
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("rejected transaction with nonzero value");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind command_latency_histogram clh_checker u_clh_checker (.*);

>>> sim/command_latency_histogram_checker.sv
// checker for the latency histogram: tracks every per-class counter, predicts each answer
// and compares it with the output stream; depends on clh_pkg
`timescale 1ns / 1ps

package clh_tb_pkg;
  import clh_pkg::*;

  typedef enum logic {MODE_RECORD = 1'b0, MODE_DRAIN = 1'b1} op_mode_t;

  localparam logic [SLOT_W-1:0] SLOT_FIRST_BUCKET = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_LAST_BUCKET  = 4'd12;
  localparam logic [SLOT_W-1:0] SLOT_SPARE_LO     = 4'd14;
  localparam logic [SLOT_W-1:0] SLOT_SPARE_HI     = 4'd15;

  localparam word_t LAT_EDGES [NUM_BUCKETS-1] = '{
    64'd100, 64'd500, 64'd1000, 64'd5000, 64'd10000, 64'd50000,
    64'd100000, 64'd500000, 64'd1000000, 64'd5000000, 64'd10000000
  };
endpackage

module command_latency_histogram_checker
  import clh_pkg::*;
  import clh_tb_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [WORD_W-1:0]    m_tdata,
  input  logic                 m_tuser,
  output int                   fail_count,
  output int                   pending_count
);

  typedef struct packed {
    word_t value;
    logic  accepted;
  } answer_t;

  word_t   class_stats [NUM_CLASSES*SLOTS_PER_CLASS];
  answer_t pending_answers [$];

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns  mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic int bucket_slot(input word_t lat);
    for (int i = 0; i < NUM_BUCKETS - 1; i++) begin
      if (lat <= LAT_EDGES[i]) return int'(SLOT_FIRST_BUCKET) + i;
    end
    return int'(SLOT_LAST_BUCKET);
  endfunction

  // updates the class statistics and returns the answer the block must give
  function automatic answer_t apply_command(input op_mode_t mode,
                                            input logic [CLASS_W-1:0] cls,
                                            input word_t lat,
                                            input logic [SLOT_W-1:0] slot);
    answer_t ans;
    int base;
    ans = '0;
    if (int'(cls) >= NUM_CLASSES) return ans;
    base = int'(cls) * SLOTS_PER_CLASS;
    ans.accepted = 1'b1;
    if (mode == MODE_RECORD) begin
      class_stats[base + int'(SLOT_TIME)] += lat;
      class_stats[base + int'(SLOT_COUNT)] += 64'd1;
      class_stats[base + bucket_slot(lat)] += 64'd1;
      ans.value = class_stats[base + int'(SLOT_TIME)];
    end else if (int'(slot) < SLOTS_PER_CLASS) begin
      ans.value = class_stats[base + int'(slot)];
      class_stats[base + int'(slot)] = '0;
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    answer_t got;
    if (rst) begin
      foreach (class_stats[i]) class_stats[i] = '0;
      pending_answers.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_answers.size() == 0) begin
          report_mismatch($sformatf("result %h/%b with nothing expected", m_tdata, m_tuser));
        end else begin
          want = pending_answers.pop_front();
          if (m_tdata !== want.value)
            report_mismatch($sformatf("value %h, expected %h", m_tdata, want.value));
          if (m_tuser !== want.accepted)
            report_mismatch($sformatf("accepted %b, expected %b", m_tuser, want.accepted));
        end
      end
      if (s_tvalid && s_tready) begin
        got = apply_command(op_mode_t'(s_tuser), s_tdata[5:0],
                            s_tdata[69:6], s_tdata[73:70]);
        pending_answers = {pending_answers, got};
      end
    end
    pending_count <= pending_answers.size();
  end

endmodule

>>> sim/command_latency_histogram_test.sv
// top of the latency histogram testbench: clock, reset, directed and random commands,
// output backpressure and the verdict; depends on clh_pkg and the checker file
`timescale 1ns / 1ps

module command_latency_histogram_test;
  import clh_pkg::*;
  import clh_tb_pkg::*;

  localparam int CLASSES      = NUM_CLASSES_DEF;
  localparam int RANDOM_ITEMS = 1125;
  localparam int PHASE1_END   = 400;
  localparam int PHASE2_END   = 800;
  localparam int HOLD_AT      = 850;
  localparam int HOLD_CYCLES  = 300;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [WORD_W-1:0]    m_tdata;
  logic                 m_tuser;
  int                   fail_count;
  int                   pending_count;
  int                   sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  command_latency_histogram #(.NUM_CLASSES(CLASSES)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  command_latency_histogram_checker #(.NUM_CLASSES(CLASSES)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  function automatic int sender_idle_pct(input int n);
    return (n < PHASE1_END) ? 22 : (n < PHASE2_END) ? 65 : 0;
  endfunction

  function automatic int receiver_idle_pct(input int n);
    return (n < PHASE1_END) ? 65 : (n < PHASE2_END) ? 22 : 0;
  endfunction

  // receiver: random stalls by phase, plus one long hold-off once the sender is at full rate
  int  rx_seen = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) rx_seen++;
      if (!hold_done && rx_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= receiver_idle_pct(rx_seen));
      end
    end
  end

  task automatic send(input op_mode_t mode, input logic [CLASS_W-1:0] cls,
                      input word_t lat, input logic [SLOT_W-1:0] slot);
    while ($urandom_range(99) < sender_idle_pct(sent)) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {6'b0, slot, lat, cls};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  function automatic word_t pick_latency();
    case ($urandom_range(3))
      0: return LAT_EDGES[$urandom_range(NUM_BUCKETS - 2)] + word_t'($urandom_range(2)) - 64'd1;
      1: return word_t'($urandom_range(20_000_000));
      2: return {$urandom, $urandom};
      default: return ~word_t'($urandom_range(1000));
    endcase
  endfunction

  initial begin
    op_mode_t             mode;
    logic [CLASS_W-1:0]   cls;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty drain, every bucket edge, wrap of total time, every kind of slot
    send(MODE_DRAIN, 6'd5, {$urandom, $urandom}, SLOT_COUNT);
    foreach (LAT_EDGES[i]) send(MODE_RECORD, 6'd0, LAT_EDGES[i], SLOT_W'($urandom_range(15)));
    send(MODE_RECORD, 6'd0, LAT_EDGES[0] + 64'd1, SLOT_SPARE_HI);
    send(MODE_RECORD, 6'd0, LAT_EDGES[NUM_BUCKETS-2] + 64'd1, SLOT_TIME);
    send(MODE_RECORD, 6'd0, '0, SLOT_COUNT);
    send(MODE_RECORD, 6'd63, '1, SLOT_W'($urandom_range(15)));
    send(MODE_RECORD, 6'd63, '1, SLOT_W'($urandom_range(15)));
    send(MODE_DRAIN, 6'd63, {$urandom, $urandom}, SLOT_TIME);
    send(MODE_DRAIN, 6'd63, {$urandom, $urandom}, SLOT_LAST_BUCKET);
    send(MODE_DRAIN, 6'd0, {$urandom, $urandom}, SLOT_SPARE_LO);
    send(MODE_DRAIN, 6'd0, {$urandom, $urandom}, SLOT_SPARE_HI);
    send(MODE_DRAIN, 6'd0, {$urandom, $urandom}, SLOT_COUNT);
    send(MODE_DRAIN, 6'd0, {$urandom, $urandom}, SLOT_FIRST_BUCKET);
    send(MODE_DRAIN, 6'd0, {$urandom, $urandom}, SLOT_FIRST_BUCKET);

    // random: mostly records on a few hot classes so the counters build up
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      mode = ($urandom_range(99) < 75) ? MODE_RECORD : MODE_DRAIN;
      cls  = ($urandom_range(99) < 60) ? CLASS_W'($urandom_range(3))
                                       : CLASS_W'($urandom_range(63));
      send(mode, cls, pick_latency(), SLOT_W'($urandom_range(15)));
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("** command_latency_histogram: PASSED **");
    end else begin
      $display("** command_latency_histogram: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_count);
    $display("** command_latency_histogram: FAILED **");
    $finish;
  end

endmodule

>>> command_latency_histogram.f
rtl/clh_pkg.sv
rtl/clh_ram.sv
rtl/command_latency_histogram.sv
rtl/clh_checker.sv
sim/command_latency_histogram_checker.sv
sim/command_latency_histogram_test.sv
